[hdl/bdf_pkg.sv]
// Package for the ITA2 asynchronous character framer.
// Holds the code table, the character class function, frame constants and types.
// No dependencies.
`default_nettype none

package bdf_pkg;

  localparam int DATA_BITS  = 5;
  localparam int FRAME_BITS = DATA_BITS + 2;
  localparam int MAX_BITS   = 2 * FRAME_BITS;
  localparam int CNT_W      = $clog2(MAX_BITS + 1);

  localparam logic [DATA_BITS-1:0] CODE_LTRS  = 5'h1f;
  localparam logic [DATA_BITS-1:0] CODE_FIGS  = 5'h1b;
  localparam logic [DATA_BITS-1:0] CODE_BLANK = 5'h00;

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_LTRS = 2'd1;
  localparam logic [1:0] MODE_FIGS = 2'd2;

  localparam logic [1:0] STOP_ONE      = 2'd0;
  localparam logic [1:0] STOP_ONE_HALF = 2'd1;
  localparam logic [1:0] STOP_TWO      = 2'd2;
  localparam logic [1:0] STOP_RESET    = STOP_ONE_HALF;

  localparam logic [2:0] HALF_BIT = 3'd2;

  localparam logic [DATA_BITS-1:0] ITA2_ROM [128] = '{
    5'h00,5'h00,5'h00,5'h00,5'h00,5'h09,5'h00,5'h0A,
    5'h08,5'h00,5'h02,5'h00,5'h00,5'h08,5'h00,5'h00,
    5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,
    5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,
    5'h04,5'h00,5'h11,5'h14,5'h09,5'h00,5'h00,5'h05,
    5'h0f,5'h12,5'h00,5'h11,5'h0c,5'h03,5'h1A,5'h1d,
    5'h16,5'h17,5'h13,5'h01,5'h0A,5'h10,5'h15,5'h07,
    5'h06,5'h18,5'h0E,5'h1e,5'h00,5'h1e,5'h00,5'h19,
    5'h00,5'h03,5'h19,5'h0E,5'h09,5'h01,5'h0D,5'h1A,
    5'h14,5'h06,5'h0b,5'h0F,5'h12,5'h1C,5'h0C,5'h18,
    5'h16,5'h17,5'h0A,5'h05,5'h10,5'h07,5'h1E,5'h13,
    5'h1D,5'h15,5'h11,5'h00,5'h00,5'h00,5'h00,5'h00,
    5'h00,5'h03,5'h19,5'h0E,5'h09,5'h01,5'h0D,5'h1A,
    5'h14,5'h06,5'h0b,5'h0F,5'h12,5'h1C,5'h0C,5'h18,
    5'h16,5'h17,5'h0A,5'h05,5'h10,5'h07,5'h1E,5'h13,
    5'h1D,5'h15,5'h11,5'h00,5'h00,5'h00,5'h00,5'h00
  };

  typedef struct packed {
    logic                 char_valid;
    logic [DATA_BITS-1:0] code;
    logic [1:0]           cls;
  } rom_rd_t;

  function automatic logic [1:0] char_class(input logic [6:0] c);
    logic [1:0] cls;
    cls = MODE_NONE;
    if (c inside {[7'd65:7'd90], [7'd97:7'd122]}) begin
      cls = MODE_LTRS;
    end else if (c inside {7'd5, 7'd7, [7'd34:7'd36], [7'd38:7'd41], [7'd43:7'd59],
                           7'd61, 7'd63}) begin
      cls = MODE_FIGS;
    end
    return cls;
  endfunction

  function automatic logic [FRAME_BITS-1:0] frame_of(input logic [DATA_BITS-1:0] code);
    return {1'b1, code, 1'b0};
  endfunction

endpackage

`default_nettype wire

[hdl/bdf_if.sv]
// Channel interfaces of the ITA2 character framer: input, result and configuration.
// Imports bdf_pkg; the field widths are written out in place.
`default_nettype none

interface bdf_in_if;
  import bdf_pkg::*;
  logic       valid;
  logic       ready;
  logic       char_valid;
  logic [7:0] char_code;
  modport source (output valid, output char_valid, output char_code, input ready);
  modport sink   (input valid, input char_valid, input char_code, output ready);
endinterface

interface bdf_out_if;
  logic       valid;
  logic       ready;
  logic       line_level;
  logic [2:0] half_bits;
  logic       last_bit;
  modport source (output valid, output line_level, output half_bits, output last_bit,
                  input ready);
  modport sink   (input valid, input line_level, input half_bits, input last_bit,
                  output ready);
endinterface

interface bdf_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] stop_length;
  modport source (output valid, output stop_length, input ready);
  modport sink   (input valid, input stop_length, output ready);
endinterface

`default_nettype wire

[hdl/bdf_rom.sv]
// Synchronous code table of the framer: one lookup per accepted transaction.
// Depends on bdf_pkg for the table, the class function and rom_rd_t.
`default_nettype none

module bdf_rom
  import bdf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rd_en,
  input  wire logic       char_valid,
  input  wire logic [7:0] char_code,
  output rom_rd_t         rd_data_r
);

  logic [6:0] addr;

  assign addr = char_code[6:0];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r.char_valid <= char_valid;
      rd_data_r.code       <= ITA2_ROM[addr];
      rd_data_r.cls        <= char_class(addr);
    end
  end

endmodule

`default_nettype wire

[hdl/bdf_serializer.sv]
// Bit serialiser of the framer: plans the shift and character frames and sends one bit
// per cycle when out_ready allows, through an output register. Holds the shift state. Depends on bdf_pkg.
`default_nettype none

module bdf_serializer
  import bdf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       st_valid,
  input  wire rom_rd_t    st_data,
  output logic            st_take,
  input  wire logic [1:0] stop_length,
  input  wire logic       out_ready,
  output logic            out_valid_r,
  output logic            line_level_r,
  output logic [2:0]      half_bits_r,
  output logic            last_bit_r
);

  logic [MAX_BITS-1:0] lev_r, lev_nxt;
  logic [MAX_BITS-1:0] stp_r, stp_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [1:0]          mode_r, mode_nxt;
  logic                emit;
  logic                shift_needed;
  logic [2:0]          stop_half;
  logic [FRAME_BITS-1:0] stop_mask;

  assign stop_mask = {1'b1, {(FRAME_BITS-1){1'b0}}};

  always_comb begin
    case (stop_length)
      STOP_ONE_HALF: stop_half = 3'd3;
      STOP_TWO:      stop_half = 3'd4;
      default:       stop_half = HALF_BIT;
    endcase
  end

  assign emit    = (cnt_r != '0) && (!out_valid_r || out_ready);
  assign st_take = st_valid && ((cnt_r == '0) || ((cnt_r == CNT_W'(1)) && emit));

  assign shift_needed = (st_data.cls != MODE_NONE) && (st_data.cls != mode_r);

  always_comb begin
    lev_nxt  = lev_r;
    stp_nxt  = stp_r;
    cnt_nxt  = cnt_r;
    mode_nxt = mode_r;
    if (st_take) begin
      if (!st_data.char_valid) begin
        lev_nxt = MAX_BITS'({frame_of(CODE_BLANK), 1'b1});
        stp_nxt = MAX_BITS'({stop_mask, 1'b0});
        cnt_nxt = CNT_W'(FRAME_BITS + 1);
      end else if (st_data.code == '0) begin
        cnt_nxt = '0;
      end else if (shift_needed) begin
        lev_nxt  = {frame_of(st_data.code),
                    frame_of((st_data.cls == MODE_LTRS) ? CODE_LTRS : CODE_FIGS)};
        stp_nxt  = {stop_mask, stop_mask};
        cnt_nxt  = CNT_W'(MAX_BITS);
        mode_nxt = st_data.cls;
      end else begin
        lev_nxt = MAX_BITS'(frame_of(st_data.code));
        stp_nxt = MAX_BITS'(stop_mask);
        cnt_nxt = CNT_W'(FRAME_BITS);
      end
    end else if (emit) begin
      lev_nxt = lev_r >> 1;
      stp_nxt = stp_r >> 1;
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      mode_r      <= MODE_NONE;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      mode_r <= mode_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lev_r <= lev_nxt;
    stp_r <= stp_nxt;
    if (emit) begin
      line_level_r <= lev_r[0];
      half_bits_r  <= stp_r[0] ? stop_half : HALF_BIT;
      last_bit_r   <= (cnt_r == CNT_W'(1));
    end
  end

endmodule

`default_nettype wire

[hdl/baudot_rtty_char_framer.sv]
// ITA2 asynchronous character framer, top level.
// An accepted transaction passes the table register and the serialiser's shift registers before its
// first result bit is registered. One result bit per cycle unless the output stalls; a character sends
// its frame, after a shift frame if needed, an idle slot a mark bit and a blank frame; one without a code is dropped.
// Reset (rst_n, synchronous): shift state none, stop length one and a half, no pending bits.
// Depends on bdf_pkg, bdf_if, bdf_rom and bdf_serializer.
`default_nettype none

module baudot_rtty_char_framer
  import bdf_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  bdf_in_if.sink     in_if,
  bdf_out_if.source  out_if,
  bdf_cfg_if.sink    cfg_if
);

  logic       st_valid_r;
  rom_rd_t    st_data_r;
  logic       st_take;
  logic       in_acc;
  logic [1:0] stop_length_r;

  assign cfg_if.ready = 1'b1;
  assign in_if.ready  = !st_valid_r || st_take;
  assign in_acc       = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r    <= 1'b0;
      stop_length_r <= STOP_RESET;
    end else begin
      if (in_acc) begin
        st_valid_r <= 1'b1;
      end else if (st_take) begin
        st_valid_r <= 1'b0;
      end
      if (cfg_if.valid) begin
        stop_length_r <= cfg_if.stop_length;
      end
    end
  end

  bdf_rom u_rom (
    .clk        (clk),
    .rd_en      (in_acc),
    .char_valid (in_if.char_valid),
    .char_code  (in_if.char_code),
    .rd_data_r  (st_data_r)
  );

  bdf_serializer u_ser (
    .clk          (clk),
    .rst_n        (rst_n),
    .st_valid     (st_valid_r),
    .st_data      (st_data_r),
    .st_take      (st_take),
    .stop_length  (stop_length_r),
    .out_ready    (out_if.ready),
    .out_valid_r  (out_if.valid),
    .line_level_r (out_if.line_level),
    .half_bits_r  (out_if.half_bits),
    .last_bit_r   (out_if.last_bit)
  );

endmodule

`default_nettype wire

[hdl/bdf_checker.sv]
// Port-level checks of the ITA2 character framer, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module bdf_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       line_level,
  input wire logic [2:0] half_bits,
  input wire logic       last_bit
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result channel valid straight after reset.");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({line_level, half_bits, last_bit}))
    else $error("Stalled result transaction changed.");

  a_half_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (half_bits == 3'd2 || half_bits == 3'd3 || half_bits == 3'd4))
    else $error("Bit duration out of range.");

  a_long_is_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && half_bits != 3'd2 |-> line_level)
    else $error("Long bit that is not a stop bit.");

endmodule

bind baudot_rtty_char_framer bdf_checker u_bdf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .line_level (out_if.line_level),
  .half_bits  (out_if.half_bits),
  .last_bit   (out_if.last_bit)
);

`default_nettype wire
